// File: hdl/stw_pkg.sv
// stw_pkg: shared types and constants of the smbios structure table walker
// holds the input and result item structs, status codes and register indexes
// no dependencies
package stw_pkg;

	localparam logic [7:0] END_TYPE = 8'd127;

	localparam logic [2:0] ST_FOUND     = 3'd0;
	localparam logic [2:0] ST_END       = 3'd1;
	localparam logic [2:0] ST_COUNT     = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_CORRUPT   = 3'd4;

	localparam logic [1:0] REG_WANTED_TYPE     = 2'd0;
	localparam logic [1:0] REG_COUNT_LIMIT_ON  = 2'd1;
	localparam logic [1:0] REG_STRUCTURE_LIMIT = 2'd2;

	typedef struct packed {
		logic [7:0] table_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] header_offset;
		logic [15:0] handle;
		logic [7:0]  formatted_length;
	} result_t;

	typedef struct packed {
		logic [7:0]  wanted_type;
		logic        count_limit_on;
		logic [15:0] structure_limit;
	} cfg_t;

endpackage

// File: hdl/stw_walker.sv
// stw_walker: structure table walk state and the per-byte decision logic
// takes one table byte per fire and reports at most one result
// depends on stw_pkg
module stw_walker #(
	parameter int OFFSET_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  stw_pkg::in_item_t item,
	input  stw_pkg::cfg_t    cfg,
	output logic             emit,
	output stw_pkg::result_t result
);
	import stw_pkg::*;

	localparam logic [1:0] PH_HEADER    = 2'd0;
	localparam logic [1:0] PH_FORMATTED = 2'd1;
	localparam logic [1:0] PH_STRINGS   = 2'd2;

	logic [1:0]             phase_q, phase_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [1:0]             hidx_q, hidx_d;
	logic [7:0]             type_q, type_d;
	logic [7:0]             len_q, len_d;
	logic [15:0]            hnd_q, hnd_d;
	logic                   pz_q, pz_d;
	logic [15:0]            cnt_q, cnt_d;
	logic [7:0]             fleft_q, fleft_d;
	logic                   done_q, done_d;
	logic                   fmt_end;
	logic [2:0]             st;

	always_comb begin
		phase_d = phase_q;
		offset_d = offset_q;
		start_d = start_q;
		hidx_d = hidx_q;
		type_d = type_q;
		len_d = len_q;
		hnd_d = hnd_q;
		pz_d = pz_q;
		cnt_d = cnt_q;
		fleft_d = fleft_q;
		done_d = done_q;
		emit = 1'b0;
		st = ST_FOUND;
		fmt_end = 1'b0;

		// first mark restarts the search
		if (item.first_byte) begin
			phase_d = PH_HEADER;
			offset_d = '0;
			start_d = '0;
			hidx_d = 2'd0;
			type_d = 8'd0;
			len_d = 8'd0;
			hnd_d = 16'd0;
			pz_d = 1'b0;
			cnt_d = 16'd0;
			fleft_d = 8'd0;
			done_d = 1'b0;
		end

		if (!done_d) begin
			unique case (phase_d)
				PH_HEADER: begin
					unique case (hidx_d)
						2'd0: begin
							start_d = offset_d;
							type_d = item.table_byte;
						end
						2'd1: len_d = item.table_byte;
						2'd2: hnd_d = {8'd0, item.table_byte};
						default: hnd_d[15:8] = item.table_byte;
					endcase
					if (hidx_d != 2'd3) begin
						hidx_d = hidx_d + 2'd1;
						if (item.last_byte) begin
							emit = 1'b1;
							st = ST_EXHAUSTED;
						end
					end else begin
						hidx_d = 2'd0;
						if (len_d < 8'd4) begin
							emit = 1'b1;
							st = ST_CORRUPT;
						end else if (len_d == 8'd4) begin
							fmt_end = 1'b1;
						end else begin
							fleft_d = len_d - 8'd4;
							phase_d = PH_FORMATTED;
							if (item.last_byte) begin
								emit = 1'b1;
								st = ST_CORRUPT;
							end
						end
					end
				end
				PH_FORMATTED: begin
					fleft_d = fleft_d - 8'd1;
					if (fleft_d == 8'd0) begin
						fmt_end = 1'b1;
					end else if (item.last_byte) begin
						emit = 1'b1;
						st = ST_CORRUPT;
					end
				end
				PH_STRINGS: begin
					if (item.table_byte == 8'd0 && pz_d) begin
						phase_d = PH_HEADER;
						pz_d = 1'b0;
						if (cfg.count_limit_on) begin
							if (cnt_d != 16'hFFFF)
								cnt_d = cnt_d + 16'd1;
						end
						if (cfg.count_limit_on && cnt_d >= cfg.structure_limit) begin
							emit = 1'b1;
							st = ST_COUNT;
						end else if (item.last_byte) begin
							emit = 1'b1;
							st = ST_EXHAUSTED;
						end
					end else begin
						pz_d = (item.table_byte == 8'd0);
						if (item.last_byte) begin
							emit = 1'b1;
							st = ST_CORRUPT;
						end
					end
				end
				default: ;
			endcase

			// formatted area complete: end marker wins over a type match
			if (fmt_end) begin
				if (type_d == END_TYPE) begin
					emit = 1'b1;
					st = ST_END;
				end else if (type_d == cfg.wanted_type) begin
					emit = 1'b1;
					st = ST_FOUND;
				end else if (item.last_byte) begin
					emit = 1'b1;
					st = ST_CORRUPT;
				end else begin
					phase_d = PH_STRINGS;
					pz_d = 1'b0;
				end
			end

			if (offset_d != '1)
				offset_d = offset_d + 1'b1;
			if (emit)
				done_d = 1'b1;
		end

		result.status = st;
		if (st == ST_FOUND) begin
			result.header_offset = 16'(start_d);
			result.handle = hnd_d;
			result.formatted_length = len_d;
		end else begin
			result.header_offset = 16'd0;
			result.handle = 16'd0;
			result.formatted_length = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			offset_q <= '0;
			start_q <= '0;
			hidx_q <= 2'd0;
			type_q <= 8'd0;
			len_q <= 8'd0;
			hnd_q <= 16'd0;
			pz_q <= 1'b0;
			cnt_q <= 16'd0;
			fleft_q <= 8'd0;
			done_q <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			offset_q <= offset_d;
			start_q <= start_d;
			hidx_q <= hidx_d;
			type_q <= type_d;
			len_q <= len_d;
			hnd_q <= hnd_d;
			pz_q <= pz_d;
			cnt_q <= cnt_d;
			fleft_q <= fleft_d;
			done_q <= done_d;
		end
	end

endmodule

// File: hdl/smbios_structure_type_finder.sv
// smbios_structure_type_finder: top level, input register, config registers,
// walker and result register; depends on stw_pkg and stw_walker
// an accepted item waits in the input register; its result is then registered in the result slot
// throughput: one table byte per cycle while the result slot is empty or draining
// reset: config to wanted_type 0, count limit on, limit 65535; walker idle
// until a byte with the first mark arrives
module smbios_structure_type_finder #(
	parameter int OFFSET_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  stw_pkg::in_item_t item,
	output logic              result_valid,
	input  logic              result_stall,
	output stw_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import stw_pkg::*;

	// configuration registers; the user must write them only while the block is idle (not enforced here)
	cfg_t     cfg_q;

	// input register stage
	logic     valid_s1;
	in_item_t item_s1;

	// result register
	logic     res_valid_q;
	result_t  res_q;

	// walker interface
	logic     advance;
	logic     emit;
	result_t  walk_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_type <= 8'd0;
			cfg_q.count_limit_on <= 1'b1;
			cfg_q.structure_limit <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WANTED_TYPE:     cfg_q.wanted_type <= cfg_data[7:0];
				REG_COUNT_LIMIT_ON:  cfg_q.count_limit_on <= cfg_data[0];
				REG_STRUCTURE_LIMIT: cfg_q.structure_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// the held item moves through the walker whenever the result slot is
	// empty or draining this cycle
	assign advance = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	stw_walker #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.emit   (emit),
		.result (walk_res)
	);

	// result slot: loaded only when free or being taken this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= walk_res;
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule
